// ----- hw/rtl/indexed_min_heap_priority_queue_unit_assert.svh -----
`ifndef INDEXED_MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_PRIORITY_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define IHPQ_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define IHPQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/ihpq_pkg.sv -----
package ihpq_pkg;

	localparam int VTX_W   = 8;
	localparam int NUM_VTX = 256;
	localparam int KEY_IO_W = 32;

	localparam logic [2:0] FN_INSERT   = 3'd0;
	localparam logic [2:0] FN_APPEND   = 3'd1;
	localparam logic [2:0] FN_POP      = 3'd2;
	localparam logic [2:0] FN_DECREASE = 3'd3;
	localparam logic [2:0] FN_CLEAR    = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;

	// write strobes towards the stores
	typedef struct packed {
		logic hs_we;       // heap slot write
		logic pi_we;       // position write, marks vertex present
		logic vld_clr;     // mark one vertex absent
		logic vld_clr_all; // mark every vertex absent
	} st_ctl_t;

	typedef struct packed {
		logic [2:0]          status;
		logic                is_empty;
		logic [KEY_IO_W-1:0] popped_key;
		logic [VTX_W-1:0]    popped_vertex;
	} res_t;

endpackage

// ----- hw/rtl/ihpq_store.sv -----
module ihpq_store
	import ihpq_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32,
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  st_ctl_t              ctl,
	input  logic [SW-1:0]        plc_slot,
	input  logic [VTX_W-1:0]     plc_vtx,
	input  logic [SW-1:0]        hs_raddr,
	output logic [VTX_W-1:0]     hs_rd,
	input  logic                 key_we,
	input  logic [VTX_W-1:0]     key_waddr,
	input  logic [KEY_WIDTH-1:0] key_wdata,
	input  logic [VTX_W-1:0]     key_raddr,
	output logic [KEY_WIDTH-1:0] key_rd,
	input  logic [VTX_W-1:0]     pi_raddr,
	output logic [SW-1:0]        pi_rd,
	input  logic [VTX_W-1:0]     vld_raddr,
	input  logic [VTX_W-1:0]     vld_caddr,
	output logic                 vld_rd
);

	logic [VTX_W-1:0]     hs_mem  [CAPACITY];
	logic [SW-1:0]        pi_mem  [NUM_VTX];
	logic [KEY_WIDTH-1:0] key_mem [NUM_VTX];
	logic [NUM_VTX-1:0]   vld_q;

	always_ff @(posedge clk) begin
		if (ctl.hs_we)
			hs_mem[plc_slot] <= plc_vtx;
		hs_rd <= hs_mem[hs_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.pi_we)
			pi_mem[plc_vtx] <= plc_slot;
		pi_rd <= pi_mem[pi_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[key_waddr] <= key_wdata;
		key_rd <= key_mem[key_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctl.vld_clr_all) begin
			vld_q <= '0;
		end else begin
			if (ctl.vld_clr)
				vld_q[vld_caddr] <= 1'b0;
			if (ctl.pi_we)
				vld_q[plc_vtx] <= 1'b1;
		end
	end

	assign vld_rd = vld_q[vld_raddr];

endmodule

// ----- hw/rtl/ihpq_seq.sv -----
module ihpq_seq
	import ihpq_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32,
	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [2:0]           in_func,
	input  logic [VTX_W-1:0]     in_vertex,
	input  logic [KEY_WIDTH-1:0] in_key,
	input  logic                 out_free,
	output logic                 idle,
	output logic                 res_load,
	output res_t                 res,
	output st_ctl_t              ctl,
	output logic [SW-1:0]        plc_slot,
	output logic [VTX_W-1:0]     plc_vtx,
	output logic [SW-1:0]        hs_raddr,
	input  logic [VTX_W-1:0]     hs_rd,
	output logic                 key_we,
	output logic [VTX_W-1:0]     key_waddr,
	output logic [KEY_WIDTH-1:0] key_wdata,
	output logic [VTX_W-1:0]     key_raddr,
	input  logic [KEY_WIDTH-1:0] key_rd,
	output logic [VTX_W-1:0]     pi_raddr,
	input  logic [SW-1:0]        pi_rd,
	output logic [VTX_W-1:0]     vld_raddr,
	output logic [VTX_W-1:0]     vld_caddr,
	input  logic                 vld_rd
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = SW + 2;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_P1   = 4'd2;
	localparam logic [3:0] S_P2   = 4'd3;
	localparam logic [3:0] S_P3   = 4'd4;
	localparam logic [3:0] S_K1   = 4'd5;
	localparam logic [3:0] S_U0   = 4'd6;
	localparam logic [3:0] S_U1   = 4'd7;
	localparam logic [3:0] S_U2   = 4'd8;
	localparam logic [3:0] S_D0   = 4'd9;
	localparam logic [3:0] S_D1   = 4'd10;
	localparam logic [3:0] S_D2   = 4'd11;
	localparam logic [3:0] S_D3   = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]           state_q;
	logic [2:0]           func_q;
	logic [VTX_W-1:0]     v_q;
	logic [KEY_WIDTH-1:0] k_q;
	logic [CW-1:0]        count_q;
	logic [SW-1:0]        slot_q;
	logic [VTX_W-1:0]     mv_q;
	logic [KEY_WIDTH-1:0] mk_q;
	logic [VTX_W-1:0]     pv_q;
	logic [VTX_W-1:0]     minv_q;
	logic [KEY_WIDTH-1:0] pk_q;
	logic [2:0]           status_q;
	logic [SW-1:0]        left_q;
	logic                 right_ok_q;
	logic [VTX_W-1:0]     lv_q;
	logic [VTX_W-1:0]     rv_q;
	logic [VTX_W-1:0]     cand_v_q;
	logic [KEY_WIDTH-1:0] cand_k_q;
	logic                 cand_mv_q;

	// the one key comparator, operands steered by state
	logic [KEY_WIDTH-1:0] cmp_a, cmp_b;
	logic                 lt;

	logic          full;
	logic [SW-1:0] parent;
	logic [LW-1:0] left_w, right_w, cnt_w;
	logic [63:0]   pk_ext;

	assign full    = (count_q == CW'(CAPACITY));
	assign parent  = SW'((slot_q - SW'(1)) >> 1);
	assign left_w  = {1'b0, slot_q, 1'b1};
	assign right_w = left_w + LW'(1);
	assign cnt_w   = LW'(count_q);
	assign lt      = (cmp_a < cmp_b);

	always_comb begin
		ctl       = '0;
		plc_slot  = slot_q;
		plc_vtx   = mv_q;
		hs_raddr  = '0;
		key_we    = 1'b0;
		key_waddr = v_q;
		key_wdata = k_q;
		key_raddr = v_q;
		pi_raddr  = v_q;
		vld_raddr = v_q;
		vld_caddr = minv_q;
		cmp_a     = key_rd;
		cmp_b     = mk_q;
		case (state_q)
			S_DEC: begin
				if ((func_q == FN_INSERT || func_q == FN_APPEND) && !vld_rd && !full) begin
					key_we = 1'b1;
					if (func_q == FN_APPEND) begin
						ctl.hs_we = 1'b1;
						ctl.pi_we = 1'b1;
						plc_slot  = count_q[SW-1:0];
						plc_vtx   = v_q;
					end
				end
				if (func_q == FN_CLEAR)
					ctl.vld_clr_all = 1'b1;
			end
			S_P1: begin
				key_raddr = hs_rd;
				hs_raddr  = SW'(count_q - CW'(1));
			end
			S_P2: begin
				ctl.vld_clr = 1'b1;
				key_raddr   = hs_rd;
			end
			S_K1: begin
				cmp_a = key_rd;
				cmp_b = k_q;
				key_we = !lt;
			end
			S_U0: begin
				if (slot_q == '0) begin
					ctl.hs_we = 1'b1;
					ctl.pi_we = 1'b1;
				end else begin
					hs_raddr = parent;
				end
			end
			S_U1: key_raddr = hs_rd;
			S_U2: begin
				cmp_a = mk_q;
				cmp_b = key_rd;
				ctl.hs_we = 1'b1;
				ctl.pi_we = 1'b1;
				if (lt)
					plc_vtx = pv_q;
			end
			S_D0: begin
				if (left_w < cnt_w) begin
					hs_raddr = left_w[SW-1:0];
				end else begin
					ctl.hs_we = 1'b1;
					ctl.pi_we = 1'b1;
				end
			end
			S_D1: begin
				key_raddr = hs_rd;
				hs_raddr  = left_q + SW'(1);
			end
			S_D2: begin
				cmp_a     = key_rd;
				cmp_b     = mk_q;
				key_raddr = hs_rd;
				if (!right_ok_q) begin
					ctl.hs_we = 1'b1;
					ctl.pi_we = 1'b1;
					if (lt)
						plc_vtx = lv_q;
				end
			end
			S_D3: begin
				cmp_a     = key_rd;
				cmp_b     = cand_k_q;
				ctl.hs_we = 1'b1;
				ctl.pi_we = 1'b1;
				plc_vtx   = lt ? rv_q : cand_v_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start)
						state_q <= S_DEC;
				end
				S_DEC: begin
					case (func_q)
						FN_INSERT, FN_APPEND: begin
							if (!vld_rd && !full) begin
								count_q <= count_q + CW'(1);
								state_q <= (func_q == FN_INSERT) ? S_U0 : S_DONE;
							end else begin
								state_q <= S_DONE;
							end
						end
						FN_POP: state_q <= (count_q != '0) ? S_P1 : S_DONE;
						FN_DECREASE: state_q <= vld_rd ? S_K1 : S_DONE;
						FN_CLEAR: begin
							count_q <= '0;
							state_q <= S_DONE;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_P1: state_q <= S_P2;
				S_P2: begin
					count_q <= count_q - CW'(1);
					state_q <= (count_q == CW'(1)) ? S_DONE : S_P3;
				end
				S_P3: state_q <= S_D0;
				S_K1: state_q <= lt ? S_DONE : S_U0;
				S_U0: state_q <= (slot_q == '0) ? S_DONE : S_U1;
				S_U1: state_q <= S_U2;
				S_U2: state_q <= lt ? S_U0 : S_DONE;
				S_D0: state_q <= (left_w < cnt_w) ? S_D1 : S_DONE;
				S_D1: state_q <= S_D2;
				S_D2: begin
					if (right_ok_q)
						state_q <= S_D3;
					else
						state_q <= lt ? S_D0 : S_DONE;
				end
				S_D3: state_q <= (lt || cand_mv_q) ? S_D0 : S_DONE;
				S_DONE: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q   <= in_func;
				v_q      <= in_vertex;
				k_q      <= in_key;
				minv_q   <= '0;
				pk_q     <= '0;
				status_q <= ST_OK;
			end
			S_DEC: begin
				case (func_q)
					FN_INSERT, FN_APPEND: begin
						if (vld_rd)
							status_q <= ST_PRESENT;
						else if (full)
							status_q <= ST_FULL;
						slot_q <= count_q[SW-1:0];
						mv_q   <= v_q;
						mk_q   <= k_q;
					end
					FN_POP: begin
						if (count_q == '0)
							status_q <= ST_EMPTY;
					end
					FN_DECREASE: begin
						if (!vld_rd)
							status_q <= ST_ABSENT;
					end
					default: ;
				endcase
			end
			S_P1: minv_q <= hs_rd;
			S_P2: begin
				pk_q <= key_rd;
				mv_q <= hs_rd;
			end
			S_P3: begin
				mk_q   <= key_rd;
				slot_q <= '0;
			end
			S_K1: begin
				slot_q <= pi_rd;
				mv_q   <= v_q;
				mk_q   <= k_q;
			end
			S_U1: pv_q <= hs_rd;
			S_U2: begin
				if (lt)
					slot_q <= parent;
			end
			S_D0: begin
				left_q     <= left_w[SW-1:0];
				right_ok_q <= (right_w < cnt_w);
			end
			S_D1: lv_q <= hs_rd;
			S_D2: begin
				rv_q      <= hs_rd;
				cand_mv_q <= lt;
				cand_v_q  <= lt ? lv_q : mv_q;
				cand_k_q  <= lt ? key_rd : mk_q;
				if (!right_ok_q && lt)
					slot_q <= left_q;
			end
			S_D3: begin
				if (lt)
					slot_q <= left_q + SW'(1);
				else if (cand_mv_q)
					slot_q <= left_q;
			end
			default: ;
		endcase
	end

	assign pk_ext = 64'(pk_q);

	assign idle     = (state_q == S_IDLE);
	assign res_load = (state_q == S_DONE) && out_free;

	always_comb begin
		res.popped_vertex = minv_q;
		res.popped_key    = pk_ext[KEY_IO_W-1:0];
		res.is_empty      = (count_q == '0);
		res.status        = status_q;
	end

endmodule

// ----- hw/rtl/indexed_min_heap_priority_queue_unit.sv -----
// Channel   Dir  Handshake          Contents
// s_*       in   s_tvalid/s_tready  tdata: vertex, key; tuser: func
// m_*       out  m_tvalid/m_tready  tdata: popped_vertex, popped_key, is_empty, status
//
// One transaction at a time; one shared key comparator, one read port per store.
// The next input is taken only after the result is loaded. Append, clear and rejected ops
// finish without walking the heap; insert climbs one level at a time until it stops;
// decrease key ends without climbing if the key rises, else climbs likewise; pop ends
// after the removal for the last entry, else moves the last entry to the root and descends.
// Reset marks every vertex absent at once; a result held by m_tready stalls the next one.
module indexed_min_heap_priority_queue_unit
	import ihpq_pkg::*;
#(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // vertex[7:0], key[39:8]
	input  logic [2:0]  s_tuser,  // func[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata   // popped_vertex[7:0], popped_key[39:8], is_empty[40],
	                              // status[43:41], zero[47:44]
);

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	st_ctl_t              ctl;
	res_t                 res, res_q;
	logic                 idle, res_load, out_free, m_tvalid_q;
	logic [SW-1:0]        plc_slot, hs_raddr, pi_rd;
	logic [VTX_W-1:0]     plc_vtx, hs_rd, key_waddr, key_raddr, pi_raddr;
	logic [VTX_W-1:0]     vld_raddr, vld_caddr;
	logic                 key_we, vld_rd;
	logic [KEY_WIDTH-1:0] key_wdata, key_rd, in_key;
	logic [63:0]          key_ext;

	assign key_ext  = 64'(s_tdata[39:8]);
	assign in_key   = key_ext[KEY_WIDTH-1:0];
	assign s_tready = idle;
	assign out_free = !m_tvalid_q || m_tready;

	ihpq_seq #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_seq (
		.clk, .arst_n,
		.start    (s_tvalid),
		.in_func  (s_tuser),
		.in_vertex(s_tdata[7:0]),
		.in_key,
		.out_free,
		.idle, .res_load, .res, .ctl,
		.plc_slot, .plc_vtx, .hs_raddr, .hs_rd,
		.key_we, .key_waddr, .key_wdata, .key_raddr, .key_rd,
		.pi_raddr, .pi_rd, .vld_raddr, .vld_caddr, .vld_rd
	);

	ihpq_store #(.CAPACITY(CAPACITY), .KEY_WIDTH(KEY_WIDTH)) u_store (
		.clk, .arst_n, .ctl,
		.plc_slot, .plc_vtx, .hs_raddr, .hs_rd,
		.key_we, .key_waddr, .key_wdata, .key_raddr, .key_rd,
		.pi_raddr, .pi_rd, .vld_raddr, .vld_caddr, .vld_rd
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (res_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_load)
			res_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, res_q};

endmodule

// ----- hw/rtl/ihpq_checker.sv -----
`include "indexed_min_heap_priority_queue_unit_assert.svh"

module ihpq_checker
	import ihpq_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata
);

	`IHPQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")
	`IHPQ_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "second transaction taken while busy")
	`IHPQ_ASSERT_NOW(a_pop_fields_zero, m_tvalid && m_tdata[43:41] != ST_OK, m_tdata[39:0] == 40'd0, "popped fields set on a failed transaction")
	`IHPQ_ASSERT_NOW(a_empty_pop_flag, m_tvalid && m_tdata[43:41] == ST_EMPTY, m_tdata[40], "empty pop without empty flag")

endmodule

bind indexed_min_heap_priority_queue_unit ihpq_checker u_ihpq_checker (.*);
